// ===== rtl/b2da_pkg.sv =====
package b2da_pkg;

	// input width and number of decimal digit cells
	localparam int VALUE_BITS = 32;
	localparam int MAX_DIGITS = 10;

	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 6;
	localparam int CNT_W   = $clog2(VALUE_BITS + 1);
	localparam int REM_W   = $clog2(MAX_DIGITS + 1);

	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

	typedef logic [DIGIT_W-1:0] digit_t;

	// control broadcast to every digit cell
	typedef struct packed {
		logic clear;
		logic dabble;
		logic shift_out;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

endpackage

// ===== rtl/b2da_cell.sv =====
module b2da_cell
	import b2da_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       carry_in,
	input  digit_t     digit_in,
	output logic       carry_out,
	output digit_t     digit
);

	digit_t digit_q;
	digit_t adj;

	// add 3 when the digit would overflow on doubling
	always_comb begin
		adj = (digit_q >= DIGIT_W'(5)) ? digit_q + DIGIT_W'(3) : digit_q;
	end

	assign carry_out = adj[DIGIT_W-1];
	assign digit     = digit_q;

	// digit register: clear, shift-and-add step, or hand digit upward
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[DIGIT_W-2:0], carry_in};
		end else if (ctrl.shift_out) begin
			digit_q <= digit_in;
		end
	end

endmodule

// ===== rtl/binary_to_decimal_ascii_unit.sv =====
// Binary to decimal ASCII converter.
//
// Request channel: drive value and pulse start while busy is low; the
// request is taken at that clock edge and busy rises in the next cycle.
// Result channel: each character appears on digit_char for exactly one
// cycle with valid high; last marks the least significant character.
// Characters come most significant first, leading zeros suppressed, and
// zero gives the single character '0'.
// Operation: after the request, shift-and-add-3 runs through the row of
// MAX_DIGITS digit cells, one input bit per cycle; then the digits shift
// out of the top cell, one per cycle, and leading zeros are shifted out
// too but give no result. The next request may be given in the cycle
// that shows the last character.
// Reset clears the control state; any run in progress is dropped.
// The receiver cannot stall: every result is shown once.
module binary_to_decimal_ascii_unit
	import b2da_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  busy,
	output logic                  valid,
	output logic [CHAR_W-1:0]     digit_char,
	output logic                  last
);

	state_t                state_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [CNT_W-1:0]      bit_cnt_q;
	logic [REM_W-1:0]      rem_q;
	logic                  seen_q;
	logic                  valid_q;
	logic [CHAR_W-1:0]     digit_char_q;
	logic                  last_q;

	cell_ctrl_t            ctrl;
	logic                  accept;
	logic                  emit;
	digit_t                digits [MAX_DIGITS];
	logic                  carry  [MAX_DIGITS+1];
	digit_t                top;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign top    = digits[MAX_DIGITS-1];

	// an output is emitted once a nonzero digit is seen, or on the final digit
	assign emit = (state_q == ST_EMIT) &&
		(seen_q || (top != '0) || (rem_q == REM_W'(1)));

	always_comb begin
		ctrl.clear     = accept;
		ctrl.dabble    = (state_q == ST_CONV);
		ctrl.shift_out = (state_q == ST_EMIT);
	end

	// row of digit cells, cell 0 least significant
	assign carry[0] = value_q[VALUE_BITS-1];

	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		digit_t din;
		if (i == 0) begin : g_first
			assign din = '0;
		end else begin : g_rest
			assign din = digits[i-1];
		end
		b2da_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.carry_in  (carry[i]),
			.digit_in  (din),
			.carry_out (carry[i+1]),
			.digit     (digits[i])
		);
	end

	// input shift register
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= value;
		end else if (state_q == ST_CONV) begin
			value_q <= {value_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			rem_q     <= '0;
			seen_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q   <= ST_CONV;
						bit_cnt_q <= CNT_W'(VALUE_BITS);
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - CNT_W'(1);
					if (bit_cnt_q == CNT_W'(1)) begin
						state_q <= ST_EMIT;
						rem_q   <= REM_W'(MAX_DIGITS);
						seen_q  <= 1'b0;
					end
				end
				ST_EMIT: begin
					rem_q <= rem_q - REM_W'(1);
					if (emit) begin
						seen_q <= 1'b1;
					end
					if (rem_q == REM_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= emit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			digit_char_q <= ASCII_ZERO + CHAR_W'(top);
			last_q       <= (rem_q == REM_W'(1));
		end
	end

	assign valid      = valid_q;
	assign digit_char = digit_char_q;
	assign last       = last_q;

	// a character is always a decimal digit
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + CHAR_W'(9)))
		else $error("digit_char out of decimal range");

	// characters of one run come back to back
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |=> valid)
		else $error("gap inside a character run");

	// the final character shows when the sequencer is already free
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |-> (state_q == ST_IDLE))
		else $error("last character while still busy");

	// a taken request starts a conversion
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && (state_q == ST_CONV))
		else $error("request not taken");

endmodule

// ===== tb/binary_to_decimal_ascii_unit_test.sv =====
`timescale 1ns / 100ps

module binary_to_decimal_ascii_unit_test;
	import b2da_pkg::*;

	localparam int DEC_BASE     = 10;
	localparam int RANDOM_ITEMS = 260;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic [VALUE_BITS-1:0] value = '0;
	logic                  busy;
	logic                  valid;
	logic [CHAR_W-1:0]     digit_char;
	logic                  last;

	// requests waiting to be driven, with the idle time after each one
	logic [VALUE_BITS-1:0] value_q [$];
	int                    gap_q [$];
	bit                    drain_q [$];

	// characters still due from the block
	logic [CHAR_W-1:0]     char_due_q [$];
	logic                  last_due_q [$];

	logic                  taken = 1'b0;
	int                    idle_left = 0;
	int                    mismatches = 0;
	logic [CHAR_W-1:0]     want_char;
	logic                  want_last;

	binary_to_decimal_ascii_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.value      (value),
		.busy       (busy),
		.valid      (valid),
		.digit_char (digit_char),
		.last       (last)
	);

	always #5 clk = ~clk;

	// decimal text of one number, most significant digit first, no leading zeros
	task automatic queue_decimal_text(input logic [VALUE_BITS-1:0] num);
		logic [63:0] rest;
		digit_t      digs [MAX_DIGITS];
		int          count;
		rest = 64'(num);
		count = 0;
		do begin
			digs[count] = digit_t'(rest % DEC_BASE);
			rest = rest / DEC_BASE;
			count++;
		end while (rest != 0 && count < MAX_DIGITS);
		for (int k = count - 1; k >= 0; k--) begin
			char_due_q.push_back(CHAR_W'(ASCII_ZERO + CHAR_W'(digs[k])));
			last_due_q.push_back(k == 0);
		end
	endtask

	task automatic add_request(input logic [VALUE_BITS-1:0] num, input int gap,
			input bit drain);
		value_q.push_back(num);
		gap_q.push_back(gap);
		drain_q.push_back(drain);
	endtask

	// request driver: holds start until taken, then idles or moves on
	always @(negedge clk) begin
		if (arst_n && !(start && !taken)) begin
			if (idle_left > 0) begin
				idle_left <= idle_left - 1;
				start <= 1'b0;
				value <= $urandom;
			end else if (value_q.size() == 0 || (drain_q[0] && char_due_q.size() != 0)) begin
				start <= 1'b0;
				value <= $urandom;
			end else begin
				start <= 1'b1;
				value <= value_q.pop_front();
				idle_left <= gap_q.pop_front();
				drain_q.delete(0);
			end
		end
	end

	// monitor: check each character, then predict for a newly taken request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken <= 1'b0;
		end else begin
			if (valid === 1'b1) begin
				if (char_due_q.size() == 0) begin
					$display("%0t: unexpected character: expected none, actual %0d last %0d",
						$time, digit_char, last);
					mismatches++;
				end else begin
					want_char = char_due_q.pop_front();
					want_last = last_due_q.pop_front();
					if (digit_char !== want_char) begin
						$display("%0t: digit_char mismatch: expected %0d, actual %0d",
							$time, want_char, digit_char);
						mismatches++;
					end
					if (last !== want_last) begin
						$display("%0t: last mismatch: expected %0d, actual %0d",
							$time, want_last, last);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				queue_decimal_text(value);
			taken <= start && !busy;
		end
	end

	// stimulus and end of run
	initial begin
		int          burst_left;
		int          gap;
		int          kind;
		int          len;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [VALUE_BITS-1:0] num;
		int          guard;

		// directed: zero, digit-count boundaries, the top of the range, bit patterns
		add_request(32'd0, 0, 1'b0);
		add_request(32'd1, 0, 1'b0);
		add_request(32'd9, 3, 1'b0);
		add_request(32'd10, 0, 1'b0);
		add_request(32'd99, 17, 1'b0);
		add_request(32'd100, 0, 1'b0);
		add_request(32'd999, 0, 1'b0);
		add_request(32'd1000, 41, 1'b0);
		add_request(32'd99999, 0, 1'b0);
		add_request(32'd100000, 0, 1'b1);
		add_request(32'd9999999, 0, 1'b0);
		add_request(32'd10000000, 2, 1'b0);
		add_request(32'd999999999, 0, 1'b0);
		add_request(32'd1000000000, 0, 1'b0);
		add_request(32'd1000000001, 30, 1'b0);
		add_request(32'd1234567890, 0, 1'b0);
		add_request(32'hFFFFFFFF, 0, 1'b0);
		add_request(32'hFFFFFFFE, 9, 1'b0);
		add_request(32'h80000000, 0, 1'b0);
		add_request(32'h7FFFFFFF, 0, 1'b0);
		add_request(32'h55555555, 0, 1'b0);
		add_request(32'hAAAAAAAA, 5, 1'b0);
		add_request(32'd4000000000, 0, 1'b0);
		add_request(32'd0, 0, 1'b1);

		// random: bursts of back-to-back requests with gaps of random length
		burst_left = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				num = ($urandom_range(0, 1) == 0) ? '0 : $urandom_range(9, 0);
			end else if (kind < 5) begin
				num = $urandom;
			end else begin
				// pick a digit count first so every length shows up often
				len = $urandom_range(1, MAX_DIGITS);
				lo = (len == 1) ? 64'd0 : 64'd1;
				hi = 64'd1;
				for (int j = 0; j < len; j++)
					hi = hi * DEC_BASE;
				for (int j = 1; j < len; j++)
					lo = lo * DEC_BASE;
				hi = hi - 1;
				if (hi > 64'hFFFFFFFF)
					hi = 64'hFFFFFFFF;
				num = $urandom_range(32'(hi), 32'(lo));
			end
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 10);
				gap = $urandom_range(1, 60);
			end else begin
				burst_left--;
				gap = 0;
			end
			add_request(num, gap, i == RANDOM_ITEMS / 2 || $urandom_range(0, 29) == 0);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for every request to be taken and every character to arrive
		while (value_q.size() != 0 || start)
			@(posedge clk);
		guard = 0;
		while (char_due_q.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
		if (char_due_q.size() != 0) begin
			$display("%0t: %0d characters never arrived, next expected %0d",
				$time, char_due_q.size(), char_due_q[0]);
			mismatches++;
		end

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== binary_to_decimal_ascii_unit.f =====
rtl/b2da_pkg.sv
rtl/b2da_cell.sv
rtl/binary_to_decimal_ascii_unit.sv
tb/binary_to_decimal_ascii_unit_test.sv
